// ===== hw/rtl/gn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types and constants of the 2D gradient noise sampler: fixed-point
// formats, skew constants, the octagon gradient table and lane control.
// ----------------------------------------------------------------------------
package gn2d_pkg;

  localparam int unsigned WF           = 24;
  localparam int unsigned PERM_ENTRIES = 256;
  localparam int unsigned HASH_W       = $clog2(PERM_ENTRIES);
  localparam int unsigned NUM_VERT     = 4;
  localparam int unsigned NUM_ADV      = 5;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SKW_W   = COORD_W + WF + 1;
  localparam int unsigned INS_W   = WF;
  localparam int unsigned SUM_W   = WF + 1;

  localparam int unsigned OFF_W = 28;
  localparam int unsigned SQ_W  = 30;
  localparam int unsigned ATN_W = SQ_W + 3;
  localparam int unsigned ATT_W = WF + 2;
  localparam int unsigned A2_W  = WF + 3;
  localparam int unsigned A4_W  = WF + 5;
  localparam int unsigned DOT_W = 32;
  localparam int unsigned CON_W = 36;
  localparam int unsigned ACC_W = 40;

  localparam int unsigned NORM_SH = 9;
  localparam int unsigned T_W     = ACC_W - NORM_SH;
  localparam int unsigned U_W     = 22;
  localparam int unsigned RCP_SH  = 32;
  localparam int unsigned RCP_W   = 27;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned OUT_W   = 16;

  localparam logic signed [22:0] STRETCH_FX = 23'sd3545443;
  localparam logic [22:0]        SQUISH_FX  = 23'd6140887;

  localparam logic signed [OFF_W-1:0] ONE_OFF = 28'sd16777216;
  localparam logic signed [OFF_W-1:0] TWO_OFF = 28'sd33554432;
  localparam logic signed [OFF_W-1:0] SQ_OFF  = 28'sd6140887;
  localparam logic signed [OFF_W-1:0] D2_OFF  = 28'sd12281774;

  localparam logic [SUM_W:0] ONE_SUM = 26'd16777216;
  localparam logic [SUM_W:0] TWO_SUM = 26'd33554432;

  localparam logic signed [ATN_W-1:0] ATN_BASE = 33'sd33554432;

  localparam logic signed [ACC_W-1:0] HALF_NORM = 40'sd12032;
  localparam logic signed [T_W-1:0]   SAT_LIM   = 31'sd1540096;
  localparam logic [RCP_W-1:0]        RCP_47    = 27'd91382282;
  localparam logic [5:0]              DIV_47    = 6'd47;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  localparam logic signed [3:0] GRAD_X [8] = '{
    4'sd5, 4'sd2, -4'sd5, -4'sd2, 4'sd5, 4'sd2, -4'sd5, -4'sd2
  };
  localparam logic signed [3:0] GRAD_Y [8] = '{
    4'sd2, 4'sd5, 4'sd2, 4'sd5, -4'sd2, -4'sd5, -4'sd2, -4'sd5
  };

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef logic signed [OFF_W-1:0] off_t;
  typedef logic signed [CON_W-1:0] con_t;

  // advance strobes for lane stages 4..8 plus the table write port
  typedef struct packed {
    logic [NUM_ADV-1:0] adv;
    logic               wr_en;
    logic [HASH_W-1:0]  wr_addr;
    logic [HASH_W-1:0]  wr_data;
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/gn2d_lane.sv =====
// ----------------------------------------------------------------------------
// gn2d_lane
// One vertex lane: private copy of the permutation table, two-level hash,
// attenuation to the fourth power and gradient dot product.
// ----------------------------------------------------------------------------
module gn2d_lane (
  input  logic                                  clk_i,
  input  gn2d_pkg::lane_ctrl_t                  ctrl_i,
  input  logic [gn2d_pkg::HASH_W-1:0]           gx_i,
  input  logic [gn2d_pkg::HASH_W-1:0]           gy_i,
  input  gn2d_pkg::off_t                        dx_i,
  input  gn2d_pkg::off_t                        dy_i,
  output gn2d_pkg::con_t                        contrib_o
);

  logic [gn2d_pkg::HASH_W-1:0] perm_mem [gn2d_pkg::PERM_ENTRIES];

  logic signed [2*gn2d_pkg::OFF_W-1:0] dx_sq, dy_sq;
  logic [gn2d_pkg::HASH_W-1:0]         h_q, gy4_q, p2_q, addr2;
  gn2d_pkg::off_t                      dx4_q, dy4_q, dx5_q, dy5_q;
  logic [gn2d_pkg::SQ_W-1:0]           sqx_q, sqy_q;
  logic signed [gn2d_pkg::ATN_W-1:0]   attn;
  logic [gn2d_pkg::ATT_W-1:0]          a_d, a_q;
  logic [2*gn2d_pkg::ATT_W-1:0]        a_sq;
  logic [gn2d_pkg::A2_W-1:0]           a2_q;
  logic [2*gn2d_pkg::A2_W-1:0]         a2_sq;
  logic [gn2d_pkg::A4_W-1:0]           a4_q;
  logic [2:0]                          gk;
  logic signed [gn2d_pkg::DOT_W-1:0]   dot_d, dot6_q, dot7_q;
  logic signed [gn2d_pkg::A4_W+gn2d_pkg::DOT_W:0] prod;
  gn2d_pkg::con_t                      con_q;

  assign dx_sq = dx_i * dx_i;
  assign dy_sq = dy_i * dy_i;
  assign addr2 = h_q + gy4_q;

  // attenuation below zero drops the vertex: a zero makes the product zero
  assign attn = gn2d_pkg::ATN_BASE - $signed({3'b000, sqx_q}) - $signed({3'b000, sqy_q});
  assign a_d  = (attn > 0) ? attn[gn2d_pkg::ATT_W-1:0] : '0;

  assign a_sq  = a_q * a_q;
  assign a2_sq = a2_q * a2_q;

  assign gk    = p2_q[3:1];
  assign dot_d = gn2d_pkg::DOT_W'(gn2d_pkg::GRAD_X[gk]) * gn2d_pkg::DOT_W'(dx5_q)
               + gn2d_pkg::DOT_W'(gn2d_pkg::GRAD_Y[gk]) * gn2d_pkg::DOT_W'(dy5_q);

  assign prod = $signed({1'b0, a4_q}) * dot7_q;

  // same-edge write and second-level read: the read returns the old entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      perm_mem[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.adv[0]) begin
      h_q <= perm_mem[gx_i];
    end
    if (ctrl_i.adv[1]) begin
      p2_q <= perm_mem[addr2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[0]) begin
      gy4_q <= gy_i;
      dx4_q <= dx_i;
      dy4_q <= dy_i;
      sqx_q <= dx_sq[gn2d_pkg::WF +: gn2d_pkg::SQ_W];
      sqy_q <= dy_sq[gn2d_pkg::WF +: gn2d_pkg::SQ_W];
    end
    if (ctrl_i.adv[1]) begin
      a_q   <= a_d;
      dx5_q <= dx4_q;
      dy5_q <= dy4_q;
    end
    if (ctrl_i.adv[2]) begin
      a2_q   <= a_sq[gn2d_pkg::WF +: gn2d_pkg::A2_W];
      dot6_q <= dot_d;
    end
    if (ctrl_i.adv[3]) begin
      a4_q   <= a2_sq[gn2d_pkg::WF +: gn2d_pkg::A4_W];
      dot7_q <= dot6_q;
    end
    if (ctrl_i.adv[4]) begin
      con_q <= prod[gn2d_pkg::WF +: gn2d_pkg::CON_W];
    end
  end

  assign contrib_o = con_q;

endmodule

// ===== hw/rtl/gradient_noise_2d_sample.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_2d_sample
// 2D OpenSimplex gradient noise, one point per transfer, Q1.15 result.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; each of the
// four vertex lanes has its own table copy, read at two addresses per cycle.
// Up to 12 items in flight.
// Reset clears the stage valid bits only; table entries are undefined until a
// load item writes them. Load items produce no result.
module gradient_noise_2d_sample #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] noise_value_o
);

  localparam int unsigned NSTG = 12;
  localparam int unsigned LAST = NSTG - 1;
  localparam int unsigned SH   = FRAC_BITS + gn2d_pkg::WF;
  localparam int unsigned HW   = gn2d_pkg::HASH_W;
  localparam int unsigned NV   = gn2d_pkg::NUM_VERT;

  logic [NSTG-1:0] v_q, en;

  // stage 0: input register
  logic           s0_act_q;
  logic [HW-1:0]  s0_tidx_q, s0_tval_q;
  logic signed [31:0] s0_x_q, s0_y_q;

  // stage 1: skewed grid origin and fractional parts
  logic           s1_act_q;
  logic [HW-1:0]  s1_tidx_q, s1_tval_q, s1_xb_q, s1_yb_q;
  logic [gn2d_pkg::INS_W-1:0] s1_xin_q, s1_yin_q;

  // stage 2: squish term
  logic           s2_act_q;
  logic [HW-1:0]  s2_tidx_q, s2_tval_q, s2_xb_q, s2_yb_q;
  logic [gn2d_pkg::INS_W-1:0] s2_xin_q, s2_yin_q, s2_sq_q;
  logic [gn2d_pkg::SUM_W-1:0] s2_sum_q;

  // stage 3: vertex selection
  logic           s3_act_q;
  logic [HW-1:0]  s3_tidx_q, s3_tval_q;
  logic [HW-1:0]  s3_gx_q [NV];
  logic [HW-1:0]  s3_gy_q [NV];
  gn2d_pkg::off_t s3_dx_q [NV];
  gn2d_pkg::off_t s3_dy_q [NV];

  // stages 9..11: normalise and saturate
  logic [gn2d_pkg::U_W-1:0] s9_u_q, s10_u_q;
  logic s9_hi_q, s9_lo_q, s10_hi_q, s10_lo_q;
  logic [gn2d_pkg::Q_W-1:0] s10_q0_q;
  logic signed [15:0] out_q;

  // ---------------------------------------------------------------- handshake
  always_comb begin
    en[LAST] = !v_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  // load items leave the pipe once their table write is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          if (k == 0) begin
            v_q[k] <= in_valid_i;
          end else if (k == 4) begin
            v_q[k] <= v_q[k-1] && (s3_act_q == gn2d_pkg::ACT_SAMPLE);
          end else begin
            v_q[k] <= v_q[k-1];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [32:0]             s0_sum;
  logic signed [gn2d_pkg::SKW_W-1:0] s0_str, s0_xsf, s0_ysf;

  assign s0_sum = 33'(s0_x_q) + 33'(s0_y_q);
  assign s0_str = s0_sum * gn2d_pkg::STRETCH_FX;
  assign s0_xsf = $signed({s0_x_q[31], s0_x_q, {gn2d_pkg::WF{1'b0}}}) - s0_str;
  assign s0_ysf = $signed({s0_y_q[31], s0_y_q, {gn2d_pkg::WF{1'b0}}}) - s0_str;

  // ---------------------------------------------------------------- stage 2
  logic [gn2d_pkg::SUM_W-1:0]   s1_sum;
  logic [gn2d_pkg::SUM_W+22:0]  s1_sqp;

  assign s1_sum = gn2d_pkg::SUM_W'(s1_xin_q) + gn2d_pkg::SUM_W'(s1_yin_q);
  assign s1_sqp = s1_sum * gn2d_pkg::SQUISH_FX;

  // ---------------------------------------------------------------- stage 3
  gn2d_pkg::off_t dx0, dy0;
  logic [gn2d_pkg::SUM_W:0] zin_lo, zin_hi, xin_w, yin_w, sum_w;
  logic lower, x_gt;
  logic [HW-1:0]  gx_d [NV];
  logic [HW-1:0]  gy_d [NV];
  gn2d_pkg::off_t dx_d [NV];
  gn2d_pkg::off_t dy_d [NV];

  always_comb begin
    dx0    = $signed(gn2d_pkg::OFF_W'(s2_xin_q)) + $signed(gn2d_pkg::OFF_W'(s2_sq_q));
    dy0    = $signed(gn2d_pkg::OFF_W'(s2_yin_q)) + $signed(gn2d_pkg::OFF_W'(s2_sq_q));
    xin_w  = (gn2d_pkg::SUM_W + 1)'(s2_xin_q);
    yin_w  = (gn2d_pkg::SUM_W + 1)'(s2_yin_q);
    sum_w  = (gn2d_pkg::SUM_W + 1)'(s2_sum_q);
    zin_lo = gn2d_pkg::ONE_SUM - sum_w;
    zin_hi = gn2d_pkg::TWO_SUM - sum_w;
    lower  = sum_w <= gn2d_pkg::ONE_SUM;
    x_gt   = s2_xin_q > s2_yin_q;

    gx_d[0] = s2_xb_q + 8'd1;
    gy_d[0] = s2_yb_q;
    dx_d[0] = dx0 - gn2d_pkg::ONE_OFF - gn2d_pkg::SQ_OFF;
    dy_d[0] = dy0 - gn2d_pkg::SQ_OFF;
    gx_d[1] = s2_xb_q;
    gy_d[1] = s2_yb_q + 8'd1;
    dx_d[1] = dx0 - gn2d_pkg::SQ_OFF;
    dy_d[1] = dy0 - gn2d_pkg::ONE_OFF - gn2d_pkg::SQ_OFF;

    if (lower) begin
      gx_d[2] = s2_xb_q;
      gy_d[2] = s2_yb_q;
      dx_d[2] = dx0;
      dy_d[2] = dy0;
      if (zin_lo > xin_w || zin_lo > yin_w) begin
        if (x_gt) begin
          gx_d[3] = s2_xb_q + 8'd1;
          gy_d[3] = s2_yb_q - 8'd1;
          dx_d[3] = dx0 - gn2d_pkg::ONE_OFF;
          dy_d[3] = dy0 + gn2d_pkg::ONE_OFF;
        end else begin
          gx_d[3] = s2_xb_q - 8'd1;
          gy_d[3] = s2_yb_q + 8'd1;
          dx_d[3] = dx0 + gn2d_pkg::ONE_OFF;
          dy_d[3] = dy0 - gn2d_pkg::ONE_OFF;
        end
      end else begin
        gx_d[3] = s2_xb_q + 8'd1;
        gy_d[3] = s2_yb_q + 8'd1;
        dx_d[3] = dx0 - gn2d_pkg::ONE_OFF - gn2d_pkg::D2_OFF;
        dy_d[3] = dy0 - gn2d_pkg::ONE_OFF - gn2d_pkg::D2_OFF;
      end
    end else begin
      gx_d[2] = s2_xb_q + 8'd1;
      gy_d[2] = s2_yb_q + 8'd1;
      dx_d[2] = dx0 - gn2d_pkg::ONE_OFF - gn2d_pkg::D2_OFF;
      dy_d[2] = dy0 - gn2d_pkg::ONE_OFF - gn2d_pkg::D2_OFF;
      if (zin_hi < xin_w || zin_hi < yin_w) begin
        if (x_gt) begin
          gx_d[3] = s2_xb_q + 8'd2;
          gy_d[3] = s2_yb_q;
          dx_d[3] = dx0 - gn2d_pkg::TWO_OFF - gn2d_pkg::D2_OFF;
          dy_d[3] = dy0 - gn2d_pkg::D2_OFF;
        end else begin
          gx_d[3] = s2_xb_q;
          gy_d[3] = s2_yb_q + 8'd2;
          dx_d[3] = dx0 - gn2d_pkg::D2_OFF;
          dy_d[3] = dy0 - gn2d_pkg::TWO_OFF - gn2d_pkg::D2_OFF;
        end
      end else begin
        gx_d[3] = s2_xb_q;
        gy_d[3] = s2_yb_q;
        dx_d[3] = dx0;
        dy_d[3] = dy0;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_act_q  <= action_i;
      s0_tidx_q <= table_index_i;
      s0_tval_q <= table_value_i;
      s0_x_q    <= x_coord_i;
      s0_y_q    <= y_coord_i;
    end
    if (en[1]) begin
      s1_act_q  <= s0_act_q;
      s1_tidx_q <= s0_tidx_q;
      s1_tval_q <= s0_tval_q;
      s1_xb_q   <= s0_xsf[SH +: HW];
      s1_yb_q   <= s0_ysf[SH +: HW];
      s1_xin_q  <= s0_xsf[FRAC_BITS +: gn2d_pkg::INS_W];
      s1_yin_q  <= s0_ysf[FRAC_BITS +: gn2d_pkg::INS_W];
    end
    if (en[2]) begin
      s2_act_q  <= s1_act_q;
      s2_tidx_q <= s1_tidx_q;
      s2_tval_q <= s1_tval_q;
      s2_xb_q   <= s1_xb_q;
      s2_yb_q   <= s1_yb_q;
      s2_xin_q  <= s1_xin_q;
      s2_yin_q  <= s1_yin_q;
      s2_sum_q  <= s1_sum;
      s2_sq_q   <= s1_sqp[gn2d_pkg::WF +: gn2d_pkg::INS_W];
    end
    if (en[3]) begin
      s3_act_q  <= s2_act_q;
      s3_tidx_q <= s2_tidx_q;
      s3_tval_q <= s2_tval_q;
      for (int i = 0; i < NV; i++) begin
        s3_gx_q[i] <= gx_d[i];
        s3_gy_q[i] <= gy_d[i];
        s3_dx_q[i] <= dx_d[i];
        s3_dy_q[i] <= dy_d[i];
      end
    end
  end

  // ---------------------------------------------------------------- lanes
  gn2d_pkg::lane_ctrl_t lane_ctrl;
  gn2d_pkg::con_t       lane_con [NV];

  assign lane_ctrl.adv     = en[8:4];
  assign lane_ctrl.wr_en   = en[4] && v_q[3] && (s3_act_q == gn2d_pkg::ACT_LOAD);
  assign lane_ctrl.wr_addr = s3_tidx_q;
  assign lane_ctrl.wr_data = s3_tval_q;

  for (genvar g = 0; g < NV; g++) begin : g_lane
    gn2d_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .gx_i      (s3_gx_q[g]),
      .gy_i      (s3_gy_q[g]),
      .dx_i      (s3_dx_q[g]),
      .dy_i      (s3_dy_q[g]),
      .contrib_o (lane_con[g])
    );
  end

  // ---------------------------------------------------------------- normalise
  logic signed [gn2d_pkg::ACC_W-1:0] acc;
  logic signed [gn2d_pkg::T_W-1:0]   t_val, t_off;
  logic [gn2d_pkg::U_W+gn2d_pkg::RCP_W-1:0] rcp_p;
  logic [gn2d_pkg::U_W:0]            rem;
  logic [gn2d_pkg::Q_W-1:0]          q_fin;
  logic signed [15:0]                out_d;

  // round half up, then floor by 2^9 before the divide by 47
  assign acc = gn2d_pkg::ACC_W'(lane_con[0]) + gn2d_pkg::ACC_W'(lane_con[1])
             + gn2d_pkg::ACC_W'(lane_con[2]) + gn2d_pkg::ACC_W'(lane_con[3])
             + gn2d_pkg::HALF_NORM;
  assign t_val = acc[gn2d_pkg::ACC_W-1:gn2d_pkg::NORM_SH];
  assign t_off = t_val + gn2d_pkg::SAT_LIM;

  assign rcp_p = s9_u_q * gn2d_pkg::RCP_47;

  // reciprocal estimate is low by at most one
  assign rem   = (gn2d_pkg::U_W + 1)'(s10_u_q)
               - (gn2d_pkg::U_W + 1)'(s10_q0_q) * (gn2d_pkg::U_W + 1)'(gn2d_pkg::DIV_47);
  assign q_fin = s10_q0_q + ((rem >= (gn2d_pkg::U_W + 1)'(gn2d_pkg::DIV_47)) ? 17'd1 : 17'd0);

  always_comb begin
    if (s10_hi_q) begin
      out_d = gn2d_pkg::OUT_MAX;
    end else if (s10_lo_q) begin
      out_d = gn2d_pkg::OUT_MIN;
    end else begin
      out_d = $signed(q_fin[15:0] ^ 16'h8000);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_hi_q <= t_val >= gn2d_pkg::SAT_LIM;
      s9_lo_q <= t_val < -gn2d_pkg::SAT_LIM;
      s9_u_q  <= t_off[gn2d_pkg::U_W-1:0];
    end
    if (en[10]) begin
      s10_hi_q <= s9_hi_q;
      s10_lo_q <= s9_lo_q;
      s10_u_q  <= s9_u_q;
      s10_q0_q <= rcp_p[gn2d_pkg::RCP_SH +: gn2d_pkg::Q_W];
    end
    if (en[11]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o   = v_q[LAST];
  assign noise_value_o = out_q;

endmodule

// ===== hw/rtl/gn2d_checker.sv =====
// ----------------------------------------------------------------------------
// gn2d_checker
// Port-level checks of the noise sampler, bound to the top level.
// ----------------------------------------------------------------------------
module gn2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [15:0] noise_value_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  // a full pipe always has a result on offer
  a_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipe not empty after reset");

endmodule

bind gradient_noise_2d_sample gn2d_checker u_gn2d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .noise_value_o (noise_value_o)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D gradient noise sampler. Loads the
// permutation table, then runs directed and random sample points through
// the block and compares each noise result with a predicted value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;

  localparam longint ONE_Q  = 64'sd16777216;
  localparam longint STR_Q  = 64'sd3545443;
  localparam longint SQU_Q  = 64'sd6140887;
  localparam longint DIV_Q  = 64'sd24064;
  localparam int     MAX_CYC = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [7:0]  table_index_i = '0;
  logic [7:0]  table_value_i = '0;
  logic signed [31:0] x_coord_i = '0;
  logic signed [31:0] y_coord_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [15:0] noise_value_o;

  gradient_noise_2d_sample u_dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic        act;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] x;
    logic [31:0] y;
    logic        known;
    logic [15:0] res;
  } stim_t;

  logic [7:0]        perm_copy [256];
  logic signed [15:0] noise_q [$];
  int  n_err = 0;
  int  cyc = 0;
  bit  hold_long = 1'b0;

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint corner(longint gx, longint gy, longint dx, longint dy);
    longint at, a2, a4, dot;
    logic [7:0] h, gi;
    int gidx;
    at = 2 * ONE_Q - ((dx * dx) >>> 24) - ((dy * dy) >>> 24);
    if (at <= 0) return 0;
    a2 = (at * at) >>> 24;
    a4 = (a2 * a2) >>> 24;
    h  = perm_copy[gx[7:0]];
    gi = perm_copy[8'(h + gy[7:0])] & 8'h0E;
    gidx = gi >> 1;
    dot = longint'(gn2d_pkg::GRAD_X[gidx]) * dx + longint'(gn2d_pkg::GRAD_Y[gidx]) * dy;
    return floor_sh(a4 * dot, 24);
  endfunction

  function automatic logic signed [15:0] predict_noise(logic signed [31:0] xi,
                                                        logic signed [31:0] yi);
    longint x, y, s, xsf, ysf, xsb, ysb, xins, yins, isum, sq, dx0, dy0;
    longint dxe, dye, xe, ye, zins, acc, q, d2;
    x = xi; y = yi; d2 = 2 * SQU_Q;
    s = x + y;
    xsf = x * ONE_Q - s * STR_Q;
    ysf = y * ONE_Q - s * STR_Q;
    xsb = xsf >>> 40;
    ysb = ysf >>> 40;
    xins = (xsf & ((64'sd1 << 40) - 1)) >>> 16;
    yins = (ysf & ((64'sd1 << 40) - 1)) >>> 16;
    isum = xins + yins;
    sq = (isum * SQU_Q) >>> 24;
    dx0 = xins + sq; dy0 = yins + sq;
    acc = corner(xsb + 1, ysb, dx0 - ONE_Q - SQU_Q, dy0 - SQU_Q);
    acc += corner(xsb, ysb + 1, dx0 - SQU_Q, dy0 - ONE_Q - SQU_Q);
    if (isum <= ONE_Q) begin
      zins = ONE_Q - isum;
      if (zins > xins || zins > yins) begin
        if (xins > yins) begin
          xe = xsb + 1; ye = ysb - 1; dxe = dx0 - ONE_Q; dye = dy0 + ONE_Q;
        end else begin
          xe = xsb - 1; ye = ysb + 1; dxe = dx0 + ONE_Q; dye = dy0 - ONE_Q;
        end
      end else begin
        xe = xsb + 1; ye = ysb + 1; dxe = dx0 - ONE_Q - d2; dye = dy0 - ONE_Q - d2;
      end
    end else begin
      zins = 2 * ONE_Q - isum;
      if (zins < xins || zins < yins) begin
        if (xins > yins) begin
          xe = xsb + 2; ye = ysb; dxe = dx0 - 2 * ONE_Q - d2; dye = dy0 - d2;
        end else begin
          xe = xsb; ye = ysb + 2; dxe = dx0 - d2; dye = dy0 - 2 * ONE_Q - d2;
        end
      end else begin
        xe = xsb; ye = ysb; dxe = dx0; dye = dy0;
      end
      xsb += 1; ysb += 1;
      dx0 = dx0 - ONE_Q - d2;
      dy0 = dy0 - ONE_Q - d2;
    end
    acc += corner(xsb, ysb, dx0, dy0);
    acc += corner(xe, ye, dxe, dye);
    acc += DIV_Q / 2;
    if (acc >= 0) q = acc / DIV_Q;
    else q = -((-acc + DIV_Q - 1) / DIV_Q);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // Send one item, honouring stall; returns after the transfer edge.
  task automatic send_item(stim_t st);
    in_valid_i    <= 1'b1;
    action_i      <= st.act;
    table_index_i <= st.idx;
    table_value_i <= st.val;
    x_coord_i     <= st.x;
    y_coord_i     <= st.y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (st.act == gn2d_pkg::ACT_LOAD) perm_copy[st.idx] = st.val;
    else if (st.known) noise_q.push_back(st.res);
    else noise_q.push_back(predict_noise(st.x, st.y));
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic stim_t load_item(int i, int v);
    stim_t st;
    st = '0;
    st.act = gn2d_pkg::ACT_LOAD; st.idx = 8'(i); st.val = 8'(v);
    st.x = $urandom; st.y = $urandom;
    return st;
  endfunction

  function automatic stim_t point_item(logic [31:0] x, logic [31:0] y);
    stim_t st;
    st = '0;
    st.act = gn2d_pkg::ACT_SAMPLE; st.idx = 8'($urandom); st.val = 8'($urandom);
    st.x = x; st.y = y;
    return st;
  endfunction

  // Receiver: random stall pattern, plus one long hold-off.
  always @(posedge clk_i) begin
    if (hold_long) out_stall_i <= 1'b1;
    else if (cyc % 64 < 20) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // hold off during the random sample stream so the pipe fills
  initial begin
    hold_long = 1'b0;
    wait (rst_ni);
    repeat (600) @(posedge clk_i);
    hold_long = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_long = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_q.size() == 0) begin
        if (n_err < 10) $display("unexpected transfer: noise %0d", noise_value_o);
        n_err <= n_err + 1;
      end else begin
        if (noise_value_o !== noise_q[0]) begin
          if (n_err < 10)
            $display("noise mismatch: expected %0d actual %0d", noise_q[0], noise_value_o);
          n_err <= n_err + 1;
        end
        void'(noise_q.pop_front());
      end
    end
    if (cyc > MAX_CYC) begin
      $display("FAIL gradient_noise_2d_sample");
      $finish;
    end
  end

  stim_t dir_tab [$];

  initial begin
    stim_t st;
    int    burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // load the whole table, with a random permutation-like fill
    for (int i = 0; i < 256; i++) begin
      send_item(load_item(i, $urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 3));
    end
    // directed points: origin, extremes, grid edges, wrap of the hash
    dir_tab.push_back(point_item(32'h0000_0000, 32'h0000_0000));
    dir_tab.push_back(point_item(32'h7fff_ffff, 32'h7fff_ffff));
    dir_tab.push_back(point_item(32'h8000_0000, 32'h8000_0000));
    dir_tab.push_back(point_item(32'h7fff_ffff, 32'h8000_0000));
    dir_tab.push_back(point_item(32'h8000_0000, 32'h7fff_ffff));
    dir_tab.push_back(point_item(32'hffff_ffff, 32'hffff_ffff));
    dir_tab.push_back(point_item(32'h0001_0000, 32'h0000_0000));
    dir_tab.push_back(point_item(32'h0000_0000, 32'h0001_0000));
    dir_tab.push_back(point_item(32'h0000_8000, 32'h0000_4000));
    dir_tab.push_back(point_item(32'h0000_4000, 32'h0000_8000));
    dir_tab.push_back(point_item(32'h0000_c000, 32'h0000_c000));
    dir_tab.push_back(point_item(32'h0100_0000, 32'hff00_0000));
    dir_tab.push_back(point_item(32'hfffe_8000, 32'h0003_2000));
    dir_tab.push_back(point_item(32'h5555_5555, 32'haaaa_aaaa));
    // loads with no result between samples: rewrite entries zero and 255
    dir_tab.push_back(load_item(0, 255));
    dir_tab.push_back(load_item(255, 0));
    dir_tab.push_back(point_item(32'h0000_0000, 32'h0000_0000));
    dir_tab.push_back(point_item(32'h00ff_0000, 32'h00ff_0000));
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    // random part: mostly samples, some table rewrites, bursty sender
    for (int n = 0; n < 330; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 330; b++, n++) begin
        if ($urandom_range(0, 9) == 0)
          st = load_item($urandom_range(0, 255), $urandom_range(0, 255));
        else if ($urandom_range(0, 3) == 0)
          st = point_item($urandom, $urandom);
        else
          st = point_item($urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000,
                          $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000);
        send_item(st);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (n_err == 0) $display("PASS gradient_noise_2d_sample");
    else $display("FAIL gradient_noise_2d_sample");
    $finish;
  end

endmodule
